// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/rar_pkg.sv =====
// Types, widths and the microcode program of the fraction add and reduce block.
package rar_pkg;

    // Field widths.
    localparam int FIELD_BITS   = 16;
    localparam int NUM_OUT_BITS = 32;
    localparam int DEN_OUT_BITS = 30;

    // Input word.
    typedef struct packed {
        logic signed [FIELD_BITS-1:0] base_numerator;
        logic        [FIELD_BITS-2:0] base_denominator;
        logic signed [FIELD_BITS-1:0] addend_numerator;
        logic        [FIELD_BITS-2:0] addend_denominator;
    } rar_in_t;

    // Output word.
    typedef struct packed {
        logic signed [NUM_OUT_BITS-1:0] sum_numerator;
        logic        [DEN_OUT_BITS-1:0] sum_denominator;
    } rar_out_t;

    // Datapath operations driven by one control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT_IN,
        OP_MUL_AD,
        OP_MUL_CB,
        OP_ADD_MUL_BD,
        OP_DEN,
        OP_GCD_INIT,
        OP_GCD_STEP,
        OP_G_FORM,
        OP_DIVN_INIT,
        OP_DIV_STEP,
        OP_DIVN_DONE,
        OP_DIVD_DONE,
        OP_EMIT
    } op_t;

    // Sequencer conditions for the step after this one.
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_HOLD_IN,
        COND_SKIP_NOTPOS,
        COND_LOOP_GCD,
        COND_LOOP_DIV,
        COND_HOLD_OUT
    } cond_t;

    localparam int PC_BITS = 4;
    typedef logic [PC_BITS-1:0] pc_t;

    // Named program addresses.
    localparam pc_t PC_FETCH     = 4'd0;
    localparam pc_t PC_MUL_AD    = 4'd1;
    localparam pc_t PC_MUL_CB    = 4'd2;
    localparam pc_t PC_ADD       = 4'd3;
    localparam pc_t PC_DEN       = 4'd4;
    localparam pc_t PC_GCD_INIT  = 4'd5;
    localparam pc_t PC_GCD_LOOP  = 4'd6;
    localparam pc_t PC_G_FORM    = 4'd7;
    localparam pc_t PC_DIVN_INIT = 4'd8;
    localparam pc_t PC_DIVN_LOOP = 4'd9;
    localparam pc_t PC_DIVN_DONE = 4'd10;
    localparam pc_t PC_DIVD_LOOP = 4'd11;
    localparam pc_t PC_DIVD_DONE = 4'd12;
    localparam pc_t PC_EMIT      = 4'd13;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ucode_t;

    // Control store: one word per program address.
    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        unique case (pc)
            PC_FETCH:     w = '{OP_WAIT_IN,    COND_HOLD_IN,     PC_FETCH};
            PC_MUL_AD:    w = '{OP_MUL_AD,     COND_NEXT,        PC_FETCH};
            PC_MUL_CB:    w = '{OP_MUL_CB,     COND_NEXT,        PC_FETCH};
            PC_ADD:       w = '{OP_ADD_MUL_BD, COND_NEXT,        PC_FETCH};
            PC_DEN:       w = '{OP_DEN,        COND_SKIP_NOTPOS, PC_EMIT};
            PC_GCD_INIT:  w = '{OP_GCD_INIT,   COND_NEXT,        PC_FETCH};
            PC_GCD_LOOP:  w = '{OP_GCD_STEP,   COND_LOOP_GCD,    PC_GCD_LOOP};
            PC_G_FORM:    w = '{OP_G_FORM,     COND_NEXT,        PC_FETCH};
            PC_DIVN_INIT: w = '{OP_DIVN_INIT,  COND_NEXT,        PC_FETCH};
            PC_DIVN_LOOP: w = '{OP_DIV_STEP,   COND_LOOP_DIV,    PC_DIVN_LOOP};
            PC_DIVN_DONE: w = '{OP_DIVN_DONE,  COND_NEXT,        PC_FETCH};
            PC_DIVD_LOOP: w = '{OP_DIV_STEP,   COND_LOOP_DIV,    PC_DIVD_LOOP};
            PC_DIVD_DONE: w = '{OP_DIVD_DONE,  COND_NEXT,        PC_FETCH};
            PC_EMIT:      w = '{OP_EMIT,       COND_HOLD_OUT,    PC_FETCH};
            default:      w = '{OP_NOP,        COND_JUMP,        PC_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== design/rational_add_reduce_top.sv =====
// Fraction adder with GCD reduction, run by a microcoded sequencer.
//
//  channel  | word      | handshake
//  ---------+-----------+------------------------------
//  item     | rar_in_t  | item_valid / item_stall
//  result   | rar_out_t | result_valid / result_stall
//
// An item whose sum or denominator is not positive skips from the denominator
// step straight to the emit step. A reduced item runs the binary GCD loop
// (one subtract or halving per cycle) and then two restoring divisions,
// which take one quotient bit per cycle through one shared subtractor.
// All control comes from a 14-word control store.
// Reset clears the program counter and the result valid; payload registers hold
// no reset. A new item is taken only at the fetch step, while a finished word
// may still wait in the result register; the emit step holds until it is free.
module rational_add_reduce_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  rar_pkg::rar_in_t   item,
    output logic               result_valid,
    input  logic               result_stall,
    output rar_pkg::rar_out_t  result
);
    import rar_pkg::*;

    `include "assert_macros.svh"

    localparam int NW = 2 * FIELD_BITS;
    localparam int DW = 2 * FIELD_BITS - 2;
    localparam int KW = $clog2(NW);
    localparam int CW = $clog2(NW);
    localparam logic [CW-1:0] CNT_LAST = CW'(NW - 1);

    // Sequencer state.
    pc_t    pc_reg, pc_next;
    ucode_t ctrl;
    logic   result_valid_reg;
    logic   out_free;

    // Datapath registers.
    rar_in_t              in_reg;
    logic signed [NW-1:0] prod_reg;
    logic signed [NW-1:0] num_reg;
    logic [DW-1:0]        den_reg;
    logic [NW-1:0]        u_reg, u_next;
    logic [NW-1:0]        v_reg, v_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [NW-1:0]        g_reg;
    logic [NW-1:0]        rem_reg, rem_next;
    logic [NW-1:0]        quo_reg, quo_next;
    logic [CW-1:0]        cnt_reg;
    rar_out_t             result_reg;

    // Shared multiplier operands.
    logic signed [FIELD_BITS-1:0] mul_x, mul_y;
    logic signed [NW-1:0]         mul_p;

    logic          not_pos;
    logic [NW:0]   div_shift, div_trial;

    assign ctrl     = ucode_rom(pc_reg);
    assign out_free = !result_valid_reg || !result_stall;
    assign not_pos  = num_reg[NW-1] || (num_reg == '0) || (prod_reg == '0);

    // Take a word only at the fetch step.
    assign item_stall   = (ctrl.op != OP_WAIT_IN);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Select the multiplier operands.
    always_comb
    begin
        unique case (ctrl.op)
            OP_MUL_AD:
            begin
                mul_x = in_reg.base_numerator;
                mul_y = $signed({1'b0, in_reg.addend_denominator});
            end
            OP_MUL_CB:
            begin
                mul_x = in_reg.addend_numerator;
                mul_y = $signed({1'b0, in_reg.base_denominator});
            end
            default:
            begin
                mul_x = $signed({1'b0, in_reg.base_denominator});
                mul_y = $signed({1'b0, in_reg.addend_denominator});
            end
        endcase
    end

    assign mul_p = NW'(mul_x) * NW'(mul_y);

    // Binary GCD step: halve even values, subtract when both are odd.
    always_comb
    begin
        u_next = u_reg;
        v_next = v_reg;
        k_next = k_reg;
        if (u_reg != v_reg)
        begin
            priority if (!u_reg[0] && !v_reg[0])
            begin
                u_next = u_reg >> 1;
                v_next = v_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!u_reg[0])
            begin
                u_next = u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_next = v_reg >> 1;
            end
            else if (u_reg > v_reg)
            begin
                u_next = u_reg - v_reg;
            end
            else
            begin
                v_next = v_reg - u_reg;
            end
        end
    end

    // Restoring division: one quotient bit per step.
    always_comb
    begin
        div_shift = {rem_reg, quo_reg[NW-1]};
        div_trial = div_shift - {1'b0, g_reg};
        rem_next  = div_trial[NW] ? div_shift[NW-1:0] : div_trial[NW-1:0];
        quo_next  = {quo_reg[NW-2:0], ~div_trial[NW]};
    end

    // Pick the next program address.
    always_comb
    begin
        pc_next = pc_reg + 1'b1;
        unique case (ctrl.cond)
            COND_NEXT:        pc_next = pc_reg + 1'b1;
            COND_JUMP:        pc_next = ctrl.target;
            COND_HOLD_IN:     pc_next = item_valid ? pc_reg + 1'b1 : pc_reg;
            COND_SKIP_NOTPOS: pc_next = not_pos ? ctrl.target : pc_reg + 1'b1;
            COND_LOOP_GCD:    pc_next = (u_reg != v_reg) ? ctrl.target : pc_reg + 1'b1;
            COND_LOOP_DIV:    pc_next = (cnt_reg != CNT_LAST) ? ctrl.target : pc_reg + 1'b1;
            COND_HOLD_OUT:    pc_next = out_free ? ctrl.target : pc_reg;
            default:          pc_next = PC_FETCH;
        endcase
    end

    // Advance the sequencer and hold the result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= PC_FETCH;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (ctrl.op == OP_EMIT && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers, one operation per control word.
    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            OP_WAIT_IN:
            begin
                if (item_valid)
                begin
                    in_reg <= item;
                end
            end
            OP_MUL_AD:
            begin
                prod_reg <= mul_p;
            end
            OP_MUL_CB:
            begin
                num_reg  <= prod_reg;
                prod_reg <= mul_p;
            end
            OP_ADD_MUL_BD:
            begin
                num_reg  <= num_reg + prod_reg;
                prod_reg <= mul_p;
            end
            OP_DEN:
            begin
                den_reg <= prod_reg[DW-1:0];
            end
            OP_GCD_INIT:
            begin
                u_reg <= num_reg;
                v_reg <= NW'(den_reg);
                k_reg <= '0;
            end
            OP_GCD_STEP:
            begin
                u_reg <= u_next;
                v_reg <= v_next;
                k_reg <= k_next;
            end
            OP_G_FORM:
            begin
                g_reg <= u_reg << k_reg;
            end
            OP_DIVN_INIT:
            begin
                quo_reg <= num_reg;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
            end
            OP_DIVN_DONE:
            begin
                num_reg <= quo_reg;
                quo_reg <= NW'(den_reg);
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            OP_DIVD_DONE:
            begin
                den_reg <= quo_reg[DW-1:0];
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    result_reg.sum_numerator   <= NUM_OUT_BITS'(num_reg);
                    result_reg.sum_denominator <= DEN_OUT_BITS'(den_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Checks on the sequencer and the reduction datapath.
    `ASSERT_NEXT(a_accept_starts, (item_valid && !item_stall), (pc_reg == PC_MUL_AD))
    `ASSERT_NEXT(a_emit_loads, (ctrl.op == OP_EMIT && out_free), result_valid)
    `ASSERT_SAME(a_gcd_nonzero, (ctrl.op == OP_GCD_STEP), (u_reg != '0 && v_reg != '0))
    `ASSERT_SAME(a_div_nonzero, (ctrl.op == OP_DIV_STEP), (g_reg != '0))

endmodule
